>>> design/tod_pkg.sv
`default_nettype none
package tod_pkg;

	typedef enum logic [2:0] {
		FMT_ASYM  = 3'd0,
		FMT_DFP   = 3'd1,
		FMT_FP32  = 3'd2,
		FMT_FP16  = 3'd3,
		FMT_INT16 = 3'd4
	} tod_fmt_t;

	localparam logic [1:0] REG_FORMAT   = 2'd0;
	localparam logic [1:0] REG_SCALE    = 2'd1;
	localparam logic [1:0] REG_ZERO_PT  = 2'd2;
	localparam logic [1:0] REG_FRAC     = 2'd3;

	localparam int          ADDR_W      = 4;
	localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
	localparam logic [31:0] QNAN        = 32'h7FC0_0000;
	localparam logic [31:0] INF         = 32'h7F80_0000;
	localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

	typedef struct packed {
		logic [2:0]  fmt;
		logic [31:0] scale;
		logic [7:0]  zero_pt;
		logic [4:0]  frac;
	} tod_cfg_t;

	// after decode and multiply: (-1)^neg * mag * 2^e, or a fixed word
	typedef struct packed {
		logic               last;
		logic               special;
		logic [31:0]        spec_val;
		logic               neg;
		logic [31:0]        mag;
		logic signed [9:0]  e;
	} tod_mag_t;

	// after normalize: top bit of norm at 31, be is the biased exponent
	typedef struct packed {
		logic               last;
		logic               special;
		logic [31:0]        spec_val;
		logic               neg;
		logic [31:0]        norm;
		logic signed [9:0]  be;
	} tod_norm_t;

	typedef struct packed {
		logic        last;
		logic        special;
		logic [31:0] spec_val;
		logic        neg;
		logic [23:0] q;
		logic        rnd;
		logic        normal;
		logic        ovf;
		logic [7:0]  be;
	} tod_rnd_t;

endpackage
`default_nettype wire

>>> design/tod_if.sv
`default_nettype none
interface tod_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] raw_element;
	logic        last_in;
	modport source (output valid, raw_element, last_in, input ready);
	modport sink (input valid, raw_element, last_in, output ready);
endinterface

interface tod_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] value_bits;
	logic        last_out;
	modport source (output valid, value_bits, last_out, input ready);
	modport sink (input valid, value_bits, last_out, output ready);
endinterface
`default_nettype wire

>>> design/tod_decode.sv
`default_nettype none
module tod_decode
	import tod_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire tod_cfg_t    cfg,
	input  wire logic [31:0] raw,
	input  wire logic        last,
	output tod_mag_t         st_s1
);

	tod_mag_t          nx;
	logic signed [8:0] d;
	logic [8:0]        d_abs;
	logic [7:0]        sc_ex;
	logic [22:0]       sc_fr;
	logic [23:0]       sc_sig;
	logic [15:0]       abs16;
	logic [4:0]        h_ex;
	logic [9:0]        h_fr;

	always_comb begin
		d      = $signed({1'b0, raw[7:0]}) - $signed({1'b0, cfg.zero_pt});
		d_abs  = d[8] ? 9'(-d) : 9'(d);
		sc_ex  = cfg.scale[30:23];
		sc_fr  = cfg.scale[22:0];
		sc_sig = {(sc_ex != 8'd0), sc_fr};
		abs16  = raw[15] ? 16'(~raw[15:0] + 16'd1) : raw[15:0];
		h_ex   = raw[14:10];
		h_fr   = raw[9:0];

		nx          = '0;
		nx.last     = last;
		case (cfg.fmt)
			FMT_ASYM: begin
				nx.neg = cfg.scale[31] ^ d[8];
				nx.mag = {24'd0, d_abs[7:0]} * {8'd0, sc_sig};
				nx.e   = (sc_ex == 8'd0) ? -10'sd149 : $signed({2'b0, sc_ex}) - 10'sd150;
				if (sc_ex == 8'hFF) begin
					nx.special = 1'b1;
					if (sc_fr != 23'd0)
						nx.spec_val = cfg.scale | QUIET_BIT;
					else if (d_abs == 9'd0)
						nx.spec_val = QNAN;
					else
						nx.spec_val = {nx.neg, INF[30:0]};
				end
			end
			FMT_DFP, FMT_INT16: begin
				nx.neg = raw[15];
				nx.mag = {16'd0, abs16};
				nx.e   = (cfg.fmt == FMT_DFP) ? -$signed({5'd0, cfg.frac}) : 10'sd0;
			end
			FMT_FP32: begin
				nx.special  = 1'b1;
				nx.spec_val = raw;
			end
			FMT_FP16: begin
				nx.neg = raw[15];
				if (h_ex == 5'h1F) begin
					nx.special  = 1'b1;
					nx.spec_val = (h_fr != 10'd0) ? {raw[15], QNAN[30:0]}
					                              : {raw[15], INF[30:0]};
				end else if (h_ex == 5'd0) begin
					nx.mag = {22'd0, h_fr};
					nx.e   = -10'sd24;
				end else begin
					nx.mag = {21'd0, 1'b1, h_fr};
					nx.e   = $signed({5'd0, h_ex}) - 10'sd25;
				end
			end
			default: begin
				nx.special  = 1'b1;
				nx.spec_val = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en)
			st_s1 <= nx;
	end

endmodule
`default_nettype wire

>>> design/tod_norm.sv
`default_nettype none
module tod_norm
	import tod_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     en,
	input  wire tod_mag_t st_s1,
	output tod_norm_t     st_s2
);

	tod_norm_t  nx;
	logic [4:0] p;

	always_comb begin
		p = 5'd0;
		for (int i = 0; i < 32; i++)
			if (st_s1.mag[i])
				p = 5'(i);
		nx.last     = st_s1.last;
		nx.neg      = st_s1.neg;
		nx.norm     = st_s1.mag << (5'd31 - p);
		nx.be       = $signed({5'd0, p}) + st_s1.e + 10'sd127;
		nx.special  = st_s1.special;
		nx.spec_val = st_s1.spec_val;
		// zero keeps its sign
		if (!st_s1.special && st_s1.mag == 32'd0) begin
			nx.special  = 1'b1;
			nx.spec_val = {st_s1.neg, 31'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			st_s2 <= nx;
	end

endmodule
`default_nettype wire

>>> design/tod_round.sv
`default_nettype none
module tod_round
	import tod_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      en,
	input  wire tod_norm_t st_s2,
	output tod_rnd_t       st_s3
);

	tod_rnd_t          nx;
	logic [4:0]        sh;
	logic signed [9:0] sub_sh;
	logic [31:0]       lost;
	logic [31:0]       half;
	logic [31:0]       q;

	always_comb begin
		nx.normal = !st_s2.be[9] && (st_s2.be != 10'sd0);
		sub_sh    = 10'sd9 - st_s2.be;
		// subnormal results drop more bits as be falls
		sh        = nx.normal ? 5'd8 : sub_sh[4:0];
		q         = st_s2.norm >> sh;
		lost      = st_s2.norm & ((32'd1 << sh) - 32'd1);
		half      = 32'd1 << (sh - 5'd1);
		nx.q      = q[23:0];
		nx.rnd    = (lost > half) || (lost == half && q[0]);
		nx.ovf    = st_s2.be >= 10'sd255;
		nx.be     = st_s2.be[7:0];
		nx.last     = st_s2.last;
		nx.neg      = st_s2.neg;
		nx.special  = st_s2.special;
		nx.spec_val = st_s2.spec_val;
	end

	always_ff @(posedge clk) begin
		if (en)
			st_s3 <= nx;
	end

endmodule
`default_nettype wire

>>> design/tod_pack.sv
`default_nettype none
module tod_pack
	import tod_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     en,
	input  wire tod_rnd_t st_s3,
	output logic [31:0]   value_s4,
	output logic          last_s4
);

	logic [30:0] base;
	logic [30:0] mag;
	logic [31:0] nx;

	always_comb begin
		base = st_s3.normal ? {st_s3.be, st_s3.q[22:0]} : {8'd0, st_s3.q[22:0]};
		// mantissa carry walks into the exponent field
		mag  = base + {30'd0, st_s3.rnd};
		if (st_s3.special)
			nx = st_s3.spec_val;
		else if (st_s3.ovf)
			nx = {st_s3.neg, INF[30:0]};
		else
			nx = {st_s3.neg, mag};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value_s4 <= nx;
			last_s4  <= st_s3.last;
		end
	end

endmodule
`default_nettype wire

>>> design/tensor_output_dequantizer_core.sv
`default_nettype none
// channel  dir  payload                      beat when
// elem     in   raw_element[31:0], last_in   valid && ready
// result   out  value_bits[31:0], last_out   valid && ready
// apb      in   regs at 0x0 0x4 0x8 0xc      psel && penable && pwrite
//
// one element per cycle while the output is not stalled; stages decode/multiply,
// normalize, round, pack, each stage one register deep
// the whole pipe advances together when the output register is empty or taken
// arst_n clears stage valids and config registers to their reset values
module tensor_output_dequantizer_core
	import tod_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	tod_in_if.sink                 elem,
	tod_out_if.source              result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	tod_cfg_t   cfg_q;
	logic [3:0] vld_q;
	logic       en;
	tod_mag_t   st_s1;
	tod_norm_t  st_s2;
	tod_rnd_t   st_s3;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fmt     <= FMT_ASYM;
			cfg_q.scale   <= SCALE_RESET;
			cfg_q.zero_pt <= 8'd0;
			cfg_q.frac    <= 5'd0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_FORMAT:  cfg_q.fmt     <= pwdata[2:0];
				REG_SCALE:   cfg_q.scale   <= pwdata;
				REG_ZERO_PT: cfg_q.zero_pt <= pwdata[7:0];
				REG_FRAC:    cfg_q.frac    <= pwdata[4:0];
				default:     cfg_q.fmt     <= cfg_q.fmt;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FORMAT:  prdata = {29'd0, cfg_q.fmt};
			REG_SCALE:   prdata = cfg_q.scale;
			REG_ZERO_PT: prdata = {24'd0, cfg_q.zero_pt};
			REG_FRAC:    prdata = {27'd0, cfg_q.frac};
			default:     prdata = 32'd0;
		endcase
	end

	assign en          = !vld_q[3] || result.ready;
	assign elem.ready  = en;
	assign result.valid = vld_q[3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 4'd0;
		else if (en)
			vld_q <= {vld_q[2:0], elem.valid};
	end

	tod_decode u_decode (
		.clk   (clk),
		.en    (en),
		.cfg   (cfg_q),
		.raw   (elem.raw_element),
		.last  (elem.last_in),
		.st_s1 (st_s1)
	);

	tod_norm u_norm (
		.clk   (clk),
		.en    (en),
		.st_s1 (st_s1),
		.st_s2 (st_s2)
	);

	tod_round u_round (
		.clk   (clk),
		.en    (en),
		.st_s2 (st_s2),
		.st_s3 (st_s3)
	);

	tod_pack u_pack (
		.clk      (clk),
		.en       (en),
		.st_s3    (st_s3),
		.value_s4 (result.value_bits),
		.last_s4  (result.last_out)
	);

endmodule
`default_nettype wire
